// File: sv/kgbfs_pkg.sv
// Package for the knight grid best-first search: sizes, codes, payload and control types.
`default_nettype none
package kgbfs_pkg;

   // Board and list sizing.
   localparam int BOARD_SIZE  = 64;
   localparam int QUEUE_DEPTH = 16384;
   localparam int CELLS       = BOARD_SIZE * BOARD_SIZE;
   localparam int CELL_W      = $clog2(CELLS);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int LINK_W      = QPTR_W + 1;

   // Field widths.
   localparam int COORD_W  = 6;
   localparam int MODE_W   = 2;
   localparam int STEPS_W  = 12;
   localparam int STATES_W = 20;
   localparam int STATUS_W = 2;
   localparam int KEY_W    = 21;

   // Knight moves.
   localparam int MOVES  = 8;
   localparam int MOVE_W = $clog2(MOVES);

   localparam logic [STEPS_W-1:0]  STEPS_INF  = {STEPS_W{1'b1}};
   localparam logic [STATES_W-1:0] STATES_MAX = {STATES_W{1'b1}};
   localparam logic [LINK_W-1:0]   LINK_NIL   = {LINK_W{1'b1}};

   // Search modes.
   localparam logic [MODE_W-1:0] MODE_ASTAR_EUC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ASTAR_MAN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GREEDY_EUC = 2'd2;
   localparam logic [MODE_W-1:0] MODE_GREEDY_MAN = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      ST_GOAL     = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_code_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] goal_x;
      logic [COORD_W-1:0] goal_y;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [STEPS_W-1:0]  path_steps;
      logic [STATES_W-1:0] states_generated;
   } rsp_type;

   // One list entry as held in the entry memory.
   typedef struct packed {
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [STEPS_W-1:0] steps;
      logic [LINK_W-1:0]  next;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load;
      logic            clr_init;
      logic            clr_step;
      logic            new_start;
      logic            new_move;
      logic            new_check;
      logic            key_new_go;
      logic            key_ent_go;
      logic            key_new_save;
      logic            walk_init;
      logic            rd_cur;
      logic            latch_ent;
      logic            advance;
      logic            alloc_wr;
      logic            link_wr;
      logic            rd_head;
      logic            pop;
      logic            move_init;
      logic            move_next;
      logic            res_load;
      status_code_type res_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic start_on_board;
      logic move_on_board;
      logic move_last;
      logic new_is_start;
      logic new_visited;
      logic key_done;
      logic key_less;
      logic key_same;
      logic cur_nil;
      logic prev_nil;
      logic full;
      logic head_nil;
      logic pop_goal;
   } stat_type;

   // Row step of each knight move.
   function automatic logic signed [2:0] move_dy(input logic [MOVE_W-1:0] m);
      logic signed [2:0] d;
      case (m)
         3'd0, 3'd1: d = -3'sd2;
         3'd2, 3'd3: d = -3'sd1;
         3'd4, 3'd5: d = 3'sd1;
         default:    d = 3'sd2;
      endcase
      return d;
   endfunction

   // Column step of each knight move.
   function automatic logic signed [2:0] move_dx(input logic [MOVE_W-1:0] m);
      logic signed [2:0] d;
      case (m)
         3'd0, 3'd6: d = -3'sd1;
         3'd1, 3'd7: d = 3'sd1;
         3'd2, 3'd4: d = -3'sd2;
         default:    d = 3'sd2;
      endcase
      return d;
   endfunction

   // Board store address of a cell, column major.
   function automatic logic [CELL_W-1:0] cell_index(input logic [COORD_W-1:0] cx,
                                                    input logic [COORD_W-1:0] cy);
      return CELL_W'(int'(cx) * BOARD_SIZE + int'(cy));
   endfunction

endpackage
`default_nettype wire

// File: sv/kgbfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kgbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: sv/kgbfs_key.sv
// Multi-cycle key unit: distance heuristics and the sort key of one cell.
`default_nettype none
module kgbfs_key (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire logic [kgbfs_pkg::MODE_W-1:0]  mode,
   input  wire logic [kgbfs_pkg::COORD_W-1:0] goal_x,
   input  wire logic [kgbfs_pkg::COORD_W-1:0] goal_y,
   input  wire logic [kgbfs_pkg::COORD_W-1:0] cell_x,
   input  wire logic [kgbfs_pkg::COORD_W-1:0] cell_y,
   input  wire logic [kgbfs_pkg::STEPS_W-1:0] g,
   output logic                               done,
   output logic [kgbfs_pkg::KEY_W-1:0]        key
);
   import kgbfs_pkg::*;

   localparam int SQ_W    = 2 * COORD_W + 1;
   localparam int V_W     = SQ_W + 14;
   localparam int TOP_BIT = ((V_W - 1) / 2) * 2;
   localparam int HM_W    = COORD_W + 1;
   // 65536/5 = 13107 + 1/5; x/5 is taken as x*6554 >> 15 for narrow x.
   localparam int DIV5_HI  = 13107;
   localparam int DIV5_REC = 6554;
   localparam int DIV5_SH  = 15;
   // y/3 is taken as y*171 >> 9 for y below 128.
   localparam int DIV3_REC = 171;
   localparam int DIV3_SH  = 9;

   typedef enum logic [1:0] {K_IDLE, K_SQ, K_DIV, K_ROOT} phase_type;

   phase_type          phase_ff;
   logic               done_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff;
   logic [STEPS_W-1:0] g_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [HM_W-1:0]    hm_ff;
   logic [V_W-1:0]     v_ff, r_ff, bit_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [V_W-1:0]     trial;
   logic [KEY_W-1:0]   key_sel;
   logic [COORD_W-1:0] adx, ady;

   // Absolute distances to the goal and the root trial value.
   always_comb begin
      adx   = (cell_x > goal_x) ? cell_x - goal_x : goal_x - cell_x;
      ady   = (cell_y > goal_y) ? cell_y - goal_y : goal_y - cell_y;
      trial = r_ff + bit_ff;
   end

   // Key selection once the root has settled.
   always_comb begin
      case (mode_ff)
         MODE_ASTAR_EUC:  key_sel = KEY_W'({g_ff, 8'h00}) + KEY_W'(r_ff);
         MODE_ASTAR_MAN:  key_sel = KEY_W'(g_ff) + KEY_W'(hm_ff);
         MODE_GREEDY_EUC: key_sel = KEY_W'(r_ff);
         default:         key_sel = KEY_W'(hm_ff);
      endcase
   end

   // Sequencer: square sum, scaled divide by five, then one root bit a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= K_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            K_IDLE: begin
               if (go) begin
                  dx_ff    <= adx;
                  dy_ff    <= ady;
                  g_ff     <= g;
                  mode_ff  <= mode;
                  phase_ff <= K_SQ;
               end
            end
            K_SQ: begin
               sq_ff    <= SQ_W'(dx_ff * dx_ff) + SQ_W'(dy_ff * dy_ff);
               hm_ff    <= HM_W'(((HM_W + 8)'(dx_ff) + (HM_W + 8)'(dy_ff))
                                 * (HM_W + 8)'(DIV3_REC) >> DIV3_SH);
               phase_ff <= K_DIV;
            end
            K_DIV: begin
               v_ff     <= V_W'(V_W'(sq_ff) * V_W'(DIV5_HI))
                           + V_W'((V_W'(sq_ff) * V_W'(DIV5_REC)) >> DIV5_SH);
               r_ff     <= '0;
               bit_ff   <= V_W'(1) << TOP_BIT;
               phase_ff <= K_ROOT;
            end
            K_ROOT: begin
               if (bit_ff == '0) begin
                  key_ff   <= key_sel;
                  done_ff  <= 1'b1;
                  phase_ff <= K_IDLE;
               end else begin
                  if (v_ff >= trial) begin
                     v_ff <= v_ff - trial;
                     r_ff <= (r_ff >> 1) + bit_ff;
                  end else begin
                     r_ff <= r_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            default: phase_ff <= K_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign key  = key_ff;

endmodule
`default_nettype wire

// File: sv/kgbfs_dpath.sv
// Datapath: board stores, entry list memory, key unit and search registers.
`default_nettype none
module kgbfs_dpath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire kgbfs_pkg::req_type req_data,
   input  wire kgbfs_pkg::cmd_type cmd,
   output kgbfs_pkg::stat_type     stat,
   output kgbfs_pkg::rsp_type      rsp_data
);
   import kgbfs_pkg::*;

   localparam int SX_W = COORD_W + 2;

   // Query registers.
   req_type             query_ff;
   // Board sweep, list pointers and counters.
   logic [CELL_W-1:0]   clr_idx_ff;
   logic [LINK_W-1:0]   head_ff, free_ff, cur_ff, prev_ff;
   logic [STATES_W-1:0] states_ff;
   logic [MOVE_W-1:0]   move_ff;
   // Expanded entry, new entry, walked entry and its predecessor.
   logic [COORD_W-1:0]  xcx_ff, xcy_ff, ncx_ff, ncy_ff, ecx_ff, ecy_ff, pcx_ff, pcy_ff;
   logic [STEPS_W-1:0]  xsteps_ff, ns_ff, esteps_ff, psteps_ff;
   logic [LINK_W-1:0]   enext_ff;
   logic                nstart_ff;
   logic [KEY_W-1:0]    knew_ff;
   rsp_type             rsp_ff;

   // Memory ports.
   logic                vis_we, vis_wdata;
   logic [CELL_W-1:0]   vis_waddr, new_idx, ent_rd_idx;
   logic [0:0]          vis_rd;
   logic                best_we;
   logic [CELL_W-1:0]   best_waddr, best_raddr;
   logic [STEPS_W-1:0]  best_wdata, best_rd;
   logic                ent_we;
   logic [QPTR_W-1:0]   ent_waddr, ent_raddr;
   entry_type           ent_wdata, ent_rd;

   // Key unit ports.
   logic                key_go, key_done;
   logic [COORD_W-1:0]  key_cx, key_cy;
   logic [STEPS_W-1:0]  key_g, g_new;
   logic [KEY_W-1:0]    key_out;

   // Move target and next step count.
   logic signed [SX_W-1:0] nx_s, ny_s;
   logic [STEPS_W-1:0]     ns_calc;
   logic                   ns_less;

   always_comb begin
      new_idx    = cell_index(ncx_ff, ncy_ff);
      ent_rd_idx = cell_index(ent_rd.cx, ent_rd.cy);
      nx_s       = $signed({2'b00, xcx_ff}) + SX_W'(move_dx(move_ff));
      ny_s       = $signed({2'b00, xcy_ff}) + SX_W'(move_dy(move_ff));
      ns_calc    = (xsteps_ff == STEPS_INF) ? STEPS_INF : STEPS_W'(xsteps_ff + 1'b1);
      ns_less    = ns_ff < best_rd;
      g_new      = (!nstart_ff && ns_less) ? ns_ff : best_rd;
   end

   // Visited store: cleared by the sweep, set when a cell is expanded.
   always_comb begin
      vis_we    = cmd.clr_step | cmd.pop;
      vis_waddr = cmd.clr_step ? clr_idx_ff : ent_rd_idx;
      vis_wdata = cmd.pop;
   end

   // Best-step store: cleared to infinity, lowered by a better successor.
   always_comb begin
      best_we    = cmd.clr_step | (cmd.new_check & ~nstart_ff & ns_less);
      best_waddr = cmd.clr_step ? clr_idx_ff : new_idx;
      best_wdata = cmd.clr_step ? STEPS_INF : ns_ff;
      best_raddr = cmd.latch_ent ? ent_rd_idx : new_idx;
   end

   // Entry memory: new entry at the free index, or relink of the predecessor.
   always_comb begin
      ent_we    = cmd.alloc_wr | cmd.link_wr;
      ent_waddr = cmd.alloc_wr ? free_ff[QPTR_W-1:0] : prev_ff[QPTR_W-1:0];
      if (cmd.alloc_wr) begin
         ent_wdata = '{cx: ncx_ff, cy: ncy_ff, steps: ns_ff, next: cur_ff};
      end else begin
         ent_wdata = '{cx: pcx_ff, cy: pcy_ff, steps: psteps_ff, next: free_ff};
      end
      ent_raddr = cmd.rd_head ? head_ff[QPTR_W-1:0] : cur_ff[QPTR_W-1:0];
   end

   // Key unit operands.
   always_comb begin
      key_go = cmd.key_new_go | cmd.key_ent_go;
      key_cx = cmd.key_new_go ? ncx_ff : ecx_ff;
      key_cy = cmd.key_new_go ? ncy_ff : ecy_ff;
      key_g  = cmd.key_new_go ? g_new : best_rd;
   end

   kgbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (vis_wdata),
      .raddr (new_idx),
      .rdata (vis_rd)
   );

   kgbfs_ram #(.WIDTH(STEPS_W), .DEPTH(CELLS)) u_best (
      .clock (clock),
      .we    (best_we),
      .waddr (best_waddr),
      .wdata (best_wdata),
      .raddr (best_raddr),
      .rdata (best_rd)
   );

   kgbfs_ram #(.WIDTH($bits(entry_type)), .DEPTH(QUEUE_DEPTH)) u_entries (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rd)
   );

   kgbfs_key u_key (
      .clock  (clock),
      .reset  (reset),
      .go     (key_go),
      .mode   (query_ff.mode),
      .goal_x (query_ff.goal_x),
      .goal_y (query_ff.goal_y),
      .cell_x (key_cx),
      .cell_y (key_cy),
      .g      (key_g),
      .done   (key_done),
      .key    (key_out)
   );

   // Control registers: sweep index, list pointers, counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
         head_ff    <= LINK_NIL;
         free_ff    <= '0;
         cur_ff     <= LINK_NIL;
         prev_ff    <= LINK_NIL;
         states_ff  <= '0;
         move_ff    <= '0;
         nstart_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            states_ff <= '0;
         end
         if (cmd.clr_init) begin
            clr_idx_ff <= '0;
            head_ff    <= LINK_NIL;
            free_ff    <= '0;
         end
         if (cmd.clr_step) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (cmd.new_start) begin
            nstart_ff <= 1'b1;
         end
         if (cmd.new_move) begin
            nstart_ff <= 1'b0;
         end
         if (cmd.new_check && !nstart_ff && states_ff != STATES_MAX) begin
            states_ff <= states_ff + 1'b1;
         end
         if (cmd.walk_init) begin
            cur_ff  <= head_ff;
            prev_ff <= LINK_NIL;
         end
         if (cmd.advance) begin
            prev_ff <= cur_ff;
            cur_ff  <= enext_ff;
         end
         if (cmd.alloc_wr) begin
            if (prev_ff == LINK_NIL) begin
               head_ff <= free_ff;
               free_ff <= free_ff + 1'b1;
            end
         end
         if (cmd.link_wr) begin
            free_ff <= free_ff + 1'b1;
         end
         if (cmd.pop) begin
            head_ff <= ent_rd.next;
         end
         if (cmd.move_init) begin
            move_ff <= '0;
         end
         if (cmd.move_next) begin
            move_ff <= move_ff + 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         query_ff <= req_data;
      end
      if (cmd.new_start) begin
         ncx_ff <= query_ff.start_x;
         ncy_ff <= query_ff.start_y;
         ns_ff  <= '0;
      end
      if (cmd.new_move) begin
         ncx_ff <= nx_s[COORD_W-1:0];
         ncy_ff <= ny_s[COORD_W-1:0];
         ns_ff  <= ns_calc;
      end
      if (cmd.key_new_save) begin
         knew_ff <= key_out;
      end
      if (cmd.latch_ent) begin
         ecx_ff    <= ent_rd.cx;
         ecy_ff    <= ent_rd.cy;
         esteps_ff <= ent_rd.steps;
         enext_ff  <= ent_rd.next;
      end
      if (cmd.advance) begin
         pcx_ff    <= ecx_ff;
         pcy_ff    <= ecy_ff;
         psteps_ff <= esteps_ff;
      end
      if (cmd.pop) begin
         xcx_ff    <= ent_rd.cx;
         xcy_ff    <= ent_rd.cy;
         xsteps_ff <= ent_rd.steps;
      end
      if (cmd.res_load) begin
         rsp_ff.status           <= cmd.res_status;
         rsp_ff.path_steps       <= (cmd.res_status == ST_GOAL) ? xsteps_ff : '0;
         rsp_ff.states_generated <= states_ff;
      end
   end

   // Status towards the controller.
   always_comb begin
      stat.clr_last       = clr_idx_ff == CELL_W'(CELLS - 1);
      stat.start_on_board = (int'(query_ff.start_x) < BOARD_SIZE)
                            && (int'(query_ff.start_y) < BOARD_SIZE);
      stat.move_on_board  = (nx_s >= 0) && (int'(nx_s) < BOARD_SIZE)
                            && (ny_s >= 0) && (int'(ny_s) < BOARD_SIZE);
      stat.move_last      = move_ff == MOVE_W'(MOVES - 1);
      stat.new_is_start   = nstart_ff;
      stat.new_visited    = vis_rd[0];
      stat.key_done       = key_done;
      stat.key_less       = knew_ff < key_out;
      stat.key_same       = (knew_ff == key_out) && (ecx_ff == ncx_ff) && (ecy_ff == ncy_ff);
      stat.cur_nil        = cur_ff == LINK_NIL;
      stat.prev_nil       = prev_ff == LINK_NIL;
      stat.full           = free_ff >= LINK_W'(QUEUE_DEPTH);
      stat.head_nil       = head_ff == LINK_NIL;
      stat.pop_goal       = (ent_rd.cx == query_ff.goal_x) && (ent_rd.cy == query_ff.goal_y);
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// File: sv/kgbfs_ctrl.sv
// Controller: query sequencing, list walk, expansion loop and handshakes.
`default_nettype none
module kgbfs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire kgbfs_pkg::stat_type stat,
   output kgbfs_pkg::cmd_type       cmd
);
   import kgbfs_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_NSTART, S_RDNEW, S_CHK, S_KEYN, S_WTEST, S_WENT,
      S_WBEST, S_WKEY, S_ALLOC, S_LINK, S_INSD, S_MNEXT, S_POP, S_PENT,
      S_MOVE, S_DONE
   } state_type;

   state_type       state_ff, state_in;
   status_code_type res_code_ff, res_code_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      res_code_in  = res_code_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.clr_init = 1'b1;
               state_in     = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               if (stat.start_on_board) begin
                  state_in = S_NSTART;
               end else begin
                  res_code_in = ST_EMPTY;
                  state_in    = S_DONE;
               end
            end
         end
         S_NSTART: begin
            cmd.new_start = 1'b1;
            state_in      = S_RDNEW;
         end
         S_RDNEW: state_in = S_CHK;
         S_CHK: begin
            if (!stat.new_is_start && stat.new_visited) begin
               state_in = S_MNEXT;
            end else begin
               cmd.new_check  = 1'b1;
               cmd.key_new_go = 1'b1;
               state_in       = S_KEYN;
            end
         end
         S_KEYN: begin
            if (stat.key_done) begin
               cmd.key_new_save = 1'b1;
               cmd.walk_init    = 1'b1;
               state_in         = S_WTEST;
            end
         end
         S_WTEST: begin
            if (stat.cur_nil) begin
               state_in = S_ALLOC;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in   = S_WENT;
            end
         end
         S_WENT: begin
            cmd.latch_ent = 1'b1;
            state_in      = S_WBEST;
         end
         S_WBEST: begin
            cmd.key_ent_go = 1'b1;
            state_in       = S_WKEY;
         end
         S_WKEY: begin
            if (stat.key_done) begin
               if (stat.key_less) begin
                  state_in = S_ALLOC;
               end else if (stat.key_same) begin
                  state_in = S_INSD;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_WTEST;
               end
            end
         end
         S_ALLOC: begin
            if (stat.full) begin
               res_code_in = ST_OVERFLOW;
               state_in    = S_DONE;
            end else begin
               cmd.alloc_wr = 1'b1;
               state_in     = stat.prev_nil ? S_INSD : S_LINK;
            end
         end
         S_LINK: begin
            cmd.link_wr = 1'b1;
            state_in    = S_INSD;
         end
         S_INSD: state_in = stat.new_is_start ? S_POP : S_MNEXT;
         S_MNEXT: begin
            if (stat.move_last) begin
               state_in = S_POP;
            end else begin
               cmd.move_next = 1'b1;
               state_in      = S_MOVE;
            end
         end
         S_POP: begin
            if (stat.head_nil) begin
               res_code_in = ST_EMPTY;
               state_in    = S_DONE;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = S_PENT;
            end
         end
         S_PENT: begin
            cmd.pop = 1'b1;
            if (stat.pop_goal) begin
               res_code_in = ST_GOAL;
               state_in    = S_DONE;
            end else begin
               cmd.move_init = 1'b1;
               state_in      = S_MOVE;
            end
         end
         S_MOVE: begin
            if (stat.move_on_board) begin
               cmd.new_move = 1'b1;
               state_in     = S_RDNEW;
            end else begin
               state_in = S_MNEXT;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = res_code_ff;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_code_ff  <= ST_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_code_ff  <= res_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: sv/knight_grid_best_first_search_top.sv
// Top level of the knight grid best-first search engine.
// One request transaction (mode, start, goal) runs a complete knight-move search and
// yields one response transaction (status, path steps, states generated). Every query
// opens with a clearing pass over the 4096-cell board stores, one cell a cycle, and
// then alternates list pops and expansions. Each insertion evaluates the new cell's key
// and then walks the sorted entry list from its head; every list node visited takes
// an entry memory read, a best-step read and a run of the key unit, whose square
// root settles one bit a cycle. One query is processed at a time; a finished
// response sits in an output register, so the next request is taken while the
// previous response waits.
`default_nettype none
module knight_grid_best_first_search_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire kgbfs_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output kgbfs_pkg::rsp_type      rsp_data
);
   import kgbfs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   kgbfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kgbfs_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   // A new request transaction makes the engine busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine still ready after taking a request");

   // Path steps are reported only when the goal was reached.
   a_steps_only_on_goal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_GOAL) |-> rsp_data.path_steps == '0)
      else $error("path steps reported without reaching the goal");

   // No entry is allocated once the list memory is exhausted.
   a_no_alloc_when_full: assert property (@(posedge clock) disable iff (reset)
      !(cmd.alloc_wr && stat.full))
      else $error("entry allocated beyond list capacity");
`endif

endmodule
`default_nettype wire

// File: dv/knight_grid_best_first_search_top_tb.sv
// Testbench for the knight grid best-first search engine: predicts each search and checks responses.
`default_nettype none
module knight_grid_best_first_search_top_tb;
   import kgbfs_pkg::*;

   localparam int NUM_RANDOM  = 80;
   localparam int MAX_COST    = 30000;
   localparam int LONG_HOLD   = 80000;
   localparam int DRAIN_WAIT  = 300;

   // Search predictor and store of expected responses.
   class search_scoreboard;
      bit               visited[CELLS];
      logic [STEPS_W-1:0] best[CELLS];
      int               ent_cx[QUEUE_DEPTH];
      int               ent_cy[QUEUE_DEPTH];
      int               ent_steps[QUEUE_DEPTH];
      int               ent_next[QUEUE_DEPTH];
      int               head;
      int               free_slot;
      int               cur_mode;
      int               tgt_x;
      int               tgt_y;
      int               cost;
      longint           cycle_budget;
      int               mismatches;
      rsp_type          expected_q[$];

      function new();
         cycle_budget = 200000 + LONG_HOLD;
         mismatches = 0;
      endfunction

      function longint unsigned int_sqrt(input longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // Ordering key of a cell from its current best step count.
      function longint unsigned cell_key(input int cx, input int cy);
         longint unsigned dx;
         longint unsigned dy;
         longint unsigned g;
         longint unsigned he;
         longint unsigned hm;
         dx = (cx > tgt_x) ? cx - tgt_x : tgt_x - cx;
         dy = (cy > tgt_y) ? cy - tgt_y : tgt_y - cy;
         g  = best[cx * BOARD_SIZE + cy];
         he = int_sqrt(((dx * dx + dy * dy) << 16) / 5);
         hm = (dx + dy) / 3;
         case (cur_mode[MODE_W-1:0])
            MODE_ASTAR_EUC: return g * 256 + he;
            MODE_ASTAR_MAN: return g + hm;
            MODE_GREEDY_EUC: return he;
            default: return hm;
         endcase
      endfunction

      // Sorted insertion; returns 0 when the entry store is exhausted.
      function bit add_entry(input int cx, input int cy, input int steps);
         longint unsigned k;
         longint unsigned kt;
         int prev;
         int cur;
         int n;
         k = cell_key(cx, cy);
         prev = -1;
         cur = head;
         cost += 25;
         while (cur != -1) begin
            cost += 22;
            kt = cell_key(ent_cx[cur], ent_cy[cur]);
            if (k < kt) break;
            if (k == kt && ent_cx[cur] == cx && ent_cy[cur] == cy) return 1'b1;
            prev = cur;
            cur = ent_next[cur];
         end
         if (free_slot >= QUEUE_DEPTH) return 1'b0;
         n = free_slot;
         free_slot++;
         ent_cx[n] = cx;
         ent_cy[n] = cy;
         ent_steps[n] = steps;
         ent_next[n] = cur;
         if (prev == -1) head = n;
         else ent_next[prev] = n;
         return 1'b1;
      endfunction

      // Runs one whole query; the cycle estimate is left in cost.
      function rsp_type search(input req_type r);
         rsp_type res;
         int states;
         int cx, cy, cs, nx, ny, ns, idx;
         bit done;
         cur_mode = r.mode;
         tgt_x = r.goal_x;
         tgt_y = r.goal_y;
         for (int i = 0; i < CELLS; i++) begin
            visited[i] = 1'b0;
            best[i] = STEPS_INF;
         end
         head = -1;
         free_slot = 0;
         cost = CELLS + 10;
         states = 0;
         done = 1'b0;
         res.status = ST_EMPTY;
         res.path_steps = '0;
         void'(add_entry(r.start_x, r.start_y, 0));
         while (!done && head != -1) begin
            cx = ent_cx[head];
            cy = ent_cy[head];
            cs = ent_steps[head];
            head = ent_next[head];
            cost += 10;
            if (cx == tgt_x && cy == tgt_y) begin
               res.status = ST_GOAL;
               res.path_steps = cs;
               break;
            end
            visited[cx * BOARD_SIZE + cy] = 1'b1;
            for (int m = 0; m < MOVES; m++) begin
               ny = cy + move_dy(m);
               nx = cx + move_dx(m);
               ns = (cs >= STEPS_INF) ? STEPS_INF : cs + 1;
               if (nx < 0 || nx >= BOARD_SIZE || ny < 0 || ny >= BOARD_SIZE) continue;
               idx = nx * BOARD_SIZE + ny;
               if (visited[idx]) continue;
               if (ns < best[idx]) best[idx] = ns;
               if (states < STATES_MAX) states++;
               if (!add_entry(nx, ny, ns)) begin
                  res.status = ST_OVERFLOW;
                  done = 1'b1;
                  break;
               end
            end
         end
         res.states_generated = states;
         return res;
      endfunction

      // An accepted request: queue its expected response.
      function void note_request(input req_type r);
         expected_q.push_back(search(r));
         cycle_budget += 4 * longint'(cost) + 5000;
      endfunction

      function void report_mismatch(input string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endfunction

      // An accepted response: compare with the oldest expectation.
      function void check_response(input rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response %p", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.path_steps !== want.path_steps)
            report_mismatch($sformatf("path_steps %0d, expected %0d",
                                      got.path_steps, want.path_steps));
         if (got.states_generated !== want.states_generated)
            report_mismatch($sformatf("states_generated %0d, expected %0d",
                                      got.states_generated, want.states_generated));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   search_scoreboard sb = new();
   longint cycles = 0;
   int     accepted = 0;
   bit     hold_done = 1'b0;

   knight_grid_best_first_search_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > sb.cycle_budget) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int short_or_long_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
      return $urandom_range(0, 4);
   endfunction

   // Offers one request transaction and waits until it is accepted.
   task automatic send_request(input req_type r);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      accepted++;
      gap = short_or_long_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_query(input logic [MODE_W-1:0] m, input int sx, input int sy,
                             input int gx, input int gy);
      req_type r;
      r.mode = m;
      r.start_x = sx;
      r.start_y = sy;
      r.goal_x = gx;
      r.goal_y = gy;
      send_request(r);
   endtask

   function automatic int clip_coord(input int v);
      return (v < 0) ? 0 : (v > BOARD_SIZE - 1) ? BOARD_SIZE - 1 : v;
   endfunction

   // Random query near its goal, kept to searches of modest length.
   task automatic random_query(output req_type r);
      int reach;
      do begin
         r.mode = $urandom_range(0, 3);
         r.start_x = $urandom_range(0, 63);
         r.start_y = $urandom_range(0, 63);
         reach = ($urandom_range(0, 4) == 0) ? 8 : 3;
         r.goal_x = clip_coord(int'(r.start_x) + $urandom_range(0, 2 * reach) - reach);
         r.goal_y = clip_coord(int'(r.start_y) + $urandom_range(0, 2 * reach) - reach);
         void'(sb.search(r));
      end while (sb.cost > MAX_COST);
   endtask

   // Receiver: random stalls, and one long hold-off while requests keep coming.
   initial begin
      int gap;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && accepted >= 30) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         gap = short_or_long_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Response checking at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // Stimulus and end of run.
   initial begin
      req_type r;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: corners, start at goal, every mode.
      for (int m = 0; m < 4; m++) begin
         send_query(m, 0, 0, 0, 0);
         send_query(m, 0, 0, 1, 2);
         send_query(m, 63, 63, 61, 62);
         send_query(m, 0, 63, 2, 62);
         send_query(m, 63, 0, 62, 2);
      end

      for (int i = 0; i < NUM_RANDOM; i++) begin
         random_query(r);
         send_request(r);
         // Let everything drain once before going on.
         if (i == 60) begin
            @(negedge clock);
            req_valid <= 1'b0;
            wait (sb.expected_q.size() == 0);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      wait (sb.expected_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
